@@ rtl/core/text_console_writer_assert.svh @@
// assertion macros for the text console writer
// every macro samples on aclk and is masked while aresetn is low
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TCW_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("text console writer: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("text console writer: next-cycle check failed");

`endif

@@ rtl/core/tcw_pkg.sv @@
`timescale 1ns / 1ps

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    // field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    // character codes
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [COL_W:0] TAB_STEP = (COL_W+1)'(4);

    // request codes
    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEPT_TOP   = 1'b1;
    localparam logic [7:0]       RESET_COLOR = 8'd10;
    localparam logic [ROW_W-1:0] RESET_KEPT  = ROW_W'(2);

    typedef struct packed {
        logic             req_type;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_col;
    } tcw_in_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              scrolled;
    } tcw_out_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } tcw_ram_cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_DONE
    } tcw_state_t;

    // logical row to physical row of the circular row store
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    // physical row and column to cell address
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

@@ rtl/core/text_console_writer.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_data  (req_type, char_code, read_row, read_col)
// m_        out        m_valid / m_ready  m_data  (cell_value, cursor_row, cursor_col, scrolled)
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// a put goes to ST_DONE; a read to ST_READ for the registered cell read, then ST_DONE.
// a scrolling put first blanks the new row's COLUMNS cells in ST_CLEAR, one write per cycle.
// after reset ST_INIT blanks all ROWS*COLUMNS cells of the store before s_ready rises.
// a result waiting on m_ready does not block the next transfer; the one after that waits.
`include "text_console_writer_assert.svh"

module text_console_writer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tcw_pkg::tcw_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tcw_pkg::tcw_out_t                 m_data,
    input  logic                              cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    tcw_pkg::tcw_ram_cmd_t      ram_cmd;
    logic [tcw_pkg::CELL_W-1:0] rd_data;
    logic                       res_valid, res_ready;
    tcw_pkg::tcw_out_t          res_data;
    logic                       m_valid_reg;
    tcw_pkg::tcw_out_t          m_data_reg;
    logic                       m_cursor_ok;

    tcw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ram_cmd   (ram_cmd),
        .rd_data   (rd_data)
    );

    tcw_cell_store u_store (
        .aclk    (aclk),
        .cmd     (ram_cmd),
        .rd_data (rd_data)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // cursor of the held result stays on the screen
    assign m_cursor_ok = (m_data.cursor_row <= tcw_pkg::ROW_LAST) &&
                         (m_data.cursor_col <= tcw_pkg::COL_LAST);

    // checks
    `TCW_ASSERT_IMPLY(a_done_blocks_input, res_valid, !s_ready)
    `TCW_ASSERT_IMPLY(a_idle_write_needs_transfer, ram_cmd.wr_en && s_ready, s_valid)
    `TCW_ASSERT_IMPLY(a_cursor_in_screen, m_valid, m_cursor_ok)
    `TCW_ASSERT_NEXT(a_result_reaches_output, res_valid && res_ready, m_valid)

endmodule

@@ rtl/core/tcw_cell_store.sv @@
`timescale 1ns / 1ps

module tcw_cell_store (
    input  logic                        aclk,
    input  tcw_pkg::tcw_ram_cmd_t       cmd,
    output logic [tcw_pkg::CELL_W-1:0]  rd_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;

    // one write port
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
    end

    // one read port, registered data
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/tcw_ctrl.sv @@
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tcw_pkg::tcw_in_t                  s_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output tcw_pkg::tcw_out_t                 res_data,
    input  logic                              cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output tcw_pkg::tcw_ram_cmd_t             ram_cmd,
    input  logic [tcw_pkg::CELL_W-1:0]        rd_data
);

    tcw_pkg::tcw_state_t state_reg, state_next;

    logic [tcw_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [tcw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]  top_reg, top_next;
    logic [7:0]                 color_reg;
    logic [tcw_pkg::ROW_W-1:0]  kept_reg;
    logic [tcw_pkg::ADDR_W-1:0] clr_addr_reg, clr_end_reg;
    logic                       rd_ok_reg;
    tcw_pkg::tcw_out_t          res_reg;

    logic                       s_transfer;
    logic                       clr_last;
    logic                       adv_row, scroll, put_wr, rd_ok;
    logic [tcw_pkg::CELL_W-1:0] put_data, blank;
    logic [tcw_pkg::ROW_W-1:0]  acc_row;
    logic [tcw_pkg::COL_W-1:0]  acc_col;
    logic [tcw_pkg::COL_W:0]    col_inc, col_tab;
    logic [tcw_pkg::ADDR_W-1:0] acc_addr, clr_base;

    assign s_transfer = s_valid && s_ready;
    assign clr_last   = (clr_addr_reg == clr_end_reg);
    assign blank      = {color_reg, tcw_pkg::CH_SPACE};
    assign col_inc    = {1'b0, col_reg} + (tcw_pkg::COL_W+1)'(1);
    assign col_tab    = {1'b0, col_reg} + tcw_pkg::TAB_STEP;
    assign acc_addr   = tcw_pkg::cell_addr(tcw_pkg::phys_row(acc_row, top_reg), acc_col);
    assign clr_base   = tcw_pkg::cell_addr(top_reg, '0);

    // cursor update and cell access for the offered request
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        top_next = top_reg;
        adv_row  = 1'b0;
        scroll   = 1'b0;
        put_wr   = 1'b0;
        put_data = blank;
        acc_row  = row_reg;
        acc_col  = col_reg;
        rd_ok    = 1'b0;
        if (s_data.req_type == tcw_pkg::REQ_READ) begin
            acc_row = s_data.read_row;
            acc_col = s_data.read_col;
            rd_ok   = ({1'b0, s_data.read_row} < (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS)) &&
                      ({1'b0, s_data.read_col} < (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS));
        end else begin
            case (s_data.char_code)
                tcw_pkg::CH_NEWLINE: begin
                    col_next = '0;
                    adv_row  = 1'b1;
                end
                tcw_pkg::CH_TAB: begin
                    if (col_tab >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS)) begin
                        col_next = tcw_pkg::COL_W'(col_tab -
                                   (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS));
                        adv_row  = 1'b1;
                    end else begin
                        col_next = col_tab[tcw_pkg::COL_W-1:0];
                    end
                end
                tcw_pkg::CH_BACKSPACE: begin
                    if (col_reg != '0) begin
                        col_next = col_reg - tcw_pkg::COL_W'(1);
                        acc_col  = col_next;
                        put_wr   = 1'b1;
                    end else if (row_reg > kept_reg) begin
                        row_next = row_reg - tcw_pkg::ROW_W'(1);
                        col_next = tcw_pkg::COL_LAST;
                        acc_row  = row_next;
                        acc_col  = tcw_pkg::COL_LAST;
                        put_wr   = 1'b1;
                    end
                end
                default: begin
                    put_wr   = 1'b1;
                    put_data = {color_reg, s_data.char_code};
                    if (col_inc >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS)) begin
                        col_next = '0;
                        adv_row  = 1'b1;
                    end else begin
                        col_next = col_inc[tcw_pkg::COL_W-1:0];
                    end
                end
            endcase
            // line advance, scrolling by rotating the top row pointer
            if (adv_row) begin
                if (row_reg == tcw_pkg::ROW_LAST) begin
                    scroll   = 1'b1;
                    top_next = (top_reg == tcw_pkg::ROW_LAST) ? '0
                               : top_reg + tcw_pkg::ROW_W'(1);
                end else begin
                    row_next = row_reg + tcw_pkg::ROW_W'(1);
                end
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_INIT: begin
                if (clr_last) state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_IDLE: begin
                if (s_transfer) begin
                    if (s_data.req_type == tcw_pkg::REQ_READ) state_next = tcw_pkg::ST_READ;
                    else if (scroll)                          state_next = tcw_pkg::ST_CLEAR;
                    else                                      state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_READ: begin
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_CLEAR: begin
                if (clr_last) state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE: begin
                if (res_ready) state_next = tcw_pkg::ST_IDLE;
            end
            default: begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and memory commands
    always_comb begin
        s_ready         = 1'b0;
        res_valid       = 1'b0;
        ram_cmd.wr_en   = 1'b0;
        ram_cmd.wr_addr = acc_addr;
        ram_cmd.wr_data = put_data;
        ram_cmd.rd_en   = 1'b0;
        ram_cmd.rd_addr = acc_addr;
        case (state_reg)
            tcw_pkg::ST_INIT: begin
                ram_cmd.wr_en   = 1'b1;
                ram_cmd.wr_addr = clr_addr_reg;
                ram_cmd.wr_data = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};
            end
            tcw_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                ram_cmd.wr_en = s_valid && put_wr;
                ram_cmd.rd_en = s_valid && rd_ok;
            end
            tcw_pkg::ST_CLEAR: begin
                ram_cmd.wr_en   = 1'b1;
                ram_cmd.wr_addr = clr_addr_reg;
                ram_cmd.wr_data = blank;
            end
            tcw_pkg::ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tcw_pkg::ST_INIT;
            row_reg      <= '0;
            col_reg      <= '0;
            top_reg      <= '0;
            color_reg    <= tcw_pkg::RESET_COLOR;
            kept_reg     <= tcw_pkg::RESET_KEPT;
            clr_addr_reg <= '0;
            clr_end_reg  <= tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
            rd_ok_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    tcw_pkg::REG_TEXT_COLOR: color_reg <= cfg_wdata;
                    tcw_pkg::REG_KEPT_TOP:   kept_reg  <= cfg_wdata[tcw_pkg::ROW_W-1:0];
                    default:                 kept_reg  <= kept_reg;
                endcase
            end
            if (s_transfer) begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                top_reg   <= top_next;
                rd_ok_reg <= rd_ok;
            end
            // clear sweep: whole store after reset, one row per scroll
            if (s_transfer && scroll) begin
                clr_addr_reg <= clr_base;
                clr_end_reg  <= clr_base + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS - 1);
            end else if (state_reg == tcw_pkg::ST_INIT || state_reg == tcw_pkg::ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + tcw_pkg::ADDR_W'(1);
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_transfer) begin
            res_reg.cell_value <= '0;
            res_reg.cursor_row <= row_next;
            res_reg.cursor_col <= col_next;
            res_reg.scrolled   <= scroll;
        end else if (state_reg == tcw_pkg::ST_READ) begin
            res_reg.cell_value <= rd_ok_reg ? rd_data : '0;
        end
    end

    assign res_data = res_reg;

endmodule
